// File: rtl/r2p_pkg.sv
// ----------------------------------------------------------------------------
// r2p_pkg: shared types and constants
// Widths, CORDIC constants, the arctangent table and the item structs
// that pass between the front end, the queue and the CORDIC back end.
// ----------------------------------------------------------------------------
package r2p_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int MAX_STEPS    = 24;
	localparam int STEPS_RUN    = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
	localparam int STEP_W       = $clog2(MAX_STEPS);

	// datapath widths: x/y with 16 fraction bits plus CORDIC growth,
	// angle accumulator in degrees with 16 fraction bits
	localparam int XW = 28;
	localparam int ZW = 25;
	localparam int TW = ZW + 1;
	localparam int PW = (XW - 1) + 32;

	// 1/K in Q0.32 with finite step correction
	localparam longint unsigned KINF = 64'd2608131496;
	localparam logic [31:0] KINV = 32'(KINF + ((KINF * 2 / 3) >> (2 * STEPS_RUN)));

	localparam logic [TW-1:0] DEG180_Q16 = TW'(11796480);
	localparam logic [TW-1:0] DEG360_Q16 = TW'(23592960);
	localparam logic [17:0]   DEG360_Q8  = 18'd92160;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// classified point as it waits in the queue
	typedef struct packed {
		logic                 origin;
		logic                 neg;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
	} cls_t;

	// CORDIC working set
	typedef struct packed {
		logic                 origin;
		logic                 neg;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic [ZW-1:0] atan_q16(input logic [STEP_W-1:0] idx);
		logic [ZW-1:0] v;
		case (idx)
			5'd0:    v = ZW'(2949120);
			5'd1:    v = ZW'(1740967);
			5'd2:    v = ZW'(919879);
			5'd3:    v = ZW'(466945);
			5'd4:    v = ZW'(234379);
			5'd5:    v = ZW'(117304);
			5'd6:    v = ZW'(58666);
			5'd7:    v = ZW'(29335);
			5'd8:    v = ZW'(14668);
			5'd9:    v = ZW'(7334);
			5'd10:   v = ZW'(3667);
			5'd11:   v = ZW'(1833);
			5'd12:   v = ZW'(917);
			5'd13:   v = ZW'(458);
			5'd14:   v = ZW'(229);
			5'd15:   v = ZW'(115);
			5'd16:   v = ZW'(57);
			5'd17:   v = ZW'(29);
			5'd18:   v = ZW'(14);
			5'd19:   v = ZW'(7);
			5'd20:   v = ZW'(4);
			5'd21:   v = ZW'(2);
			5'd22:   v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/r2p_front.sv
// ----------------------------------------------------------------------------
// r2p_front: input stage and classifier
// Takes a point, flags the origin, folds the left half plane onto the
// right one and scales to the CORDIC datapath format.
// ----------------------------------------------------------------------------
module r2p_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pt_valid,
	output logic                  pt_stall,
	input  logic signed [15:0]    x_coord,
	input  logic signed [15:0]    y_coord,
	input  logic                  q_full,
	output logic                  push,
	output r2p_pkg::cls_t         push_d
);

	logic                          valid_s1;
	r2p_pkg::cls_t                 cls_s1;
	r2p_pkg::cls_t                 cls_d;
	logic signed [r2p_pkg::XW-1:0] xe;
	logic signed [r2p_pkg::XW-1:0] ye;
	logic                          accept;

	always_comb begin
		xe            = r2p_pkg::XW'(x_coord);
		ye            = r2p_pkg::XW'(y_coord);
		cls_d.origin  = (x_coord == 16'sd0) && (y_coord == 16'sd0);
		cls_d.neg     = x_coord[15];
		// rotate by 180 degrees when x < 0
		if (x_coord[15]) begin
			xe = -xe;
			ye = -ye;
		end
		cls_d.x = xe <<< 8;
		cls_d.y = ye <<< 8;
	end

	assign push     = valid_s1 && !q_full;
	assign pt_stall = valid_s1 && q_full;
	assign accept   = pt_valid && !pt_stall;
	assign push_d   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

// File: rtl/r2p_queue.sv
// ----------------------------------------------------------------------------
// r2p_queue: small FIFO between front end and CORDIC back end
// Register-based, first-word fall-through on the read side.
// ----------------------------------------------------------------------------
module r2p_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  r2p_pkg::cls_t push_d,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output r2p_pkg::cls_t head
);

	r2p_pkg::cls_t                mem_q [r2p_pkg::QDEPTH];
	logic [r2p_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [r2p_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [r2p_pkg::QPTR_W:0]     count_q;

	assign full  = (count_q == (r2p_pkg::QPTR_W + 1)'(r2p_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_d;
		end
	end

endmodule

// File: rtl/r2p_rot.sv
// ----------------------------------------------------------------------------
// r2p_rot: one CORDIC micro-rotation stage, vectoring mode
// Drives y toward zero and accumulates the rotated angle. The step
// index is tied to a constant at each instance.
// ----------------------------------------------------------------------------
module r2p_rot (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [r2p_pkg::STEP_W-1:0]   step,
	input  logic                         in_valid,
	input  r2p_pkg::rot_t                in_d,
	output logic                         out_valid,
	output r2p_pkg::rot_t                out_d
);

	logic                          valid_s1;
	r2p_pkg::rot_t                 rot_s1;
	r2p_pkg::rot_t                 nxt;
	logic signed [r2p_pkg::XW-1:0] dx;
	logic signed [r2p_pkg::XW-1:0] dy;
	logic signed [r2p_pkg::ZW-1:0] da;

	always_comb begin
		dx  = in_d.y >>> step;
		dy  = in_d.x >>> step;
		da  = signed'(r2p_pkg::atan_q16(step));
		nxt = in_d;
		if (!in_d.y[r2p_pkg::XW-1]) begin
			nxt.x = in_d.x + dx;
			nxt.y = in_d.y - dy;
			nxt.z = in_d.z + da;
		end else begin
			nxt.x = in_d.x - dx;
			nxt.y = in_d.y + dy;
			nxt.z = in_d.z - da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_d     = rot_s1;

endmodule

// File: rtl/r2p_back.sv
// ----------------------------------------------------------------------------
// r2p_back: CORDIC pipeline, gain correction and angle wrap
// One stage per micro-rotation, then a multiply stage and the output
// register. The whole pipeline holds while the output is stalled.
// ----------------------------------------------------------------------------
module r2p_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  r2p_pkg::cls_t head,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [15:0]   magnitude,
	output logic [16:0]   angle_deg
);

	logic                          en;
	logic                          stg_v [r2p_pkg::STEPS_RUN + 1];
	r2p_pkg::rot_t                 stg_d [r2p_pkg::STEPS_RUN + 1];

	logic                          valid_s1;
	logic                          origin_s1;
	logic [r2p_pkg::PW-1:0]        prod_s1;
	logic [r2p_pkg::TW-2:0]        theta_s1;

	logic                          valid_s2;
	logic [15:0]                   mag_s2;
	logic [16:0]                   ang_s2;

	r2p_pkg::rot_t                 fin;
	logic [r2p_pkg::XW-2:0]        xpos;
	logic signed [r2p_pkg::TW-1:0] theta;
	logic [r2p_pkg::PW:0]          rsum;
	logic [r2p_pkg::PW-40:0]       mag_full;
	logic [17:0]                   ang_r;
	logic [15:0]                   mag_d;
	logic [16:0]                   ang_d;

	assign en  = !(valid_s2 && res_stall);
	assign pop = en && !q_empty;

	always_comb begin
		stg_v[0]        = !q_empty;
		stg_d[0].origin = head.origin;
		stg_d[0].neg    = head.neg;
		stg_d[0].x      = head.x;
		stg_d[0].y      = head.y;
		stg_d[0].z      = '0;
	end

	for (genvar g = 0; g < r2p_pkg::STEPS_RUN; g++) begin : g_rot
		r2p_rot u_rot (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (r2p_pkg::STEP_W'(g)),
			.in_valid  (stg_v[g]),
			.in_d      (stg_d[g]),
			.out_valid (stg_v[g+1]),
			.out_d     (stg_d[g+1])
		);
	end

	// gain correction product and angle base/wrap
	always_comb begin
		fin  = stg_d[r2p_pkg::STEPS_RUN];
		xpos = (fin.x > 0) ? fin.x[r2p_pkg::XW-2:0] : '0;
		theta = (fin.neg ? signed'(r2p_pkg::DEG180_Q16) : '0) + r2p_pkg::TW'(fin.z);
		if (theta[r2p_pkg::TW-1]) begin
			theta = theta + signed'(r2p_pkg::DEG360_Q16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= stg_v[r2p_pkg::STEPS_RUN];
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			origin_s1 <= fin.origin;
			prod_s1   <= r2p_pkg::PW'(xpos) * r2p_pkg::PW'(r2p_pkg::KINV);
			theta_s1  <= theta[r2p_pkg::TW-2:0];
		end
	end

	// round, saturate, wrap 360 to 0; origin forces zero
	always_comb begin
		rsum     = {1'b0, prod_s1} + ((r2p_pkg::PW + 1)'(1) << 39);
		mag_full = rsum[r2p_pkg::PW:40];
		ang_r    = 18'((theta_s1 + (r2p_pkg::TW - 1)'(128)) >> 8);
		if (ang_r >= r2p_pkg::DEG360_Q8) begin
			ang_r = ang_r - r2p_pkg::DEG360_Q8;
		end
		mag_d = (mag_full > (r2p_pkg::PW - 39)'(16'hFFFF)) ? 16'hFFFF : mag_full[15:0];
		ang_d = ang_r[16:0];
		if (origin_s1) begin
			mag_d = '0;
			ang_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_d;
			ang_s2 <= ang_d;
		end
	end

	assign res_valid = valid_s2;
	assign magnitude = mag_s2;
	assign angle_deg = ang_s2;

endmodule

// File: rtl/rect_to_polar_degrees.sv
// ----------------------------------------------------------------------------
// rect_to_polar_degrees: rectangular to polar converter
// Gain-compensated CORDIC in vectoring mode, degrees output.
// ----------------------------------------------------------------------------
// Usage:
//   Point channel (pt_valid / pt_stall, x_coord, y_coord): one item is a
//   point in signed Q8.8. It is taken on a rising edge with pt_valid high
//   and pt_stall low.
//   Result channel (res_valid / res_stall, magnitude, angle_deg): one item
//   per point, in order. magnitude is unsigned Q8.8 (rounded, saturating),
//   angle_deg is unsigned Q9.8 in [0, 360). The origin gives 0 / 0.
//   Throughput: one item per cycle while res_stall is low. From accept to
//   res_valid an item passes the input register, the queue, one register
//   per CORDIC micro-rotation, the gain multiply and the output register.
//   res_stall freezes the back-end pipeline; the front end keeps taking
//   items into its 4-entry queue until it fills, then pt_stall rises.
//   arst_n clears all valid bits and queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
module rect_to_polar_degrees (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_stall,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [15:0]        magnitude,
	output logic [16:0]        angle_deg
);

	// front end -> queue
	logic          push;
	r2p_pkg::cls_t push_d;
	logic          q_full;

	// queue -> back end
	logic          q_empty;
	logic          pop;
	r2p_pkg::cls_t head;

	// classify: origin flag, left-half fold, scale to datapath
	r2p_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.q_full   (q_full),
		.push     (push),
		.push_d   (push_d)
	);

	// decouples input acceptance from output back-pressure
	r2p_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_d (push_d),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	// unrolled CORDIC, 1/K scaling, angle base and wrap
	r2p_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.magnitude (magnitude),
		.angle_deg (angle_deg)
	);

endmodule

// File: tb/sv/rect_to_polar_degrees_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_to_polar_degrees_tb: self-checking bench for the polar converter
// Drives points on the valid/stall input channel and checks every result item
// against a bit-exact CORDIC predictor, with random gaps and stalls.
// ----------------------------------------------------------------------------
module rect_to_polar_degrees_tb;

	// CORDIC rotation count as the block runs it (table stops at 24)
	localparam int ROT_STEPS = (r2p_pkg::CORDIC_STEPS > 24) ? 24 : r2p_pkg::CORDIC_STEPS;

	localparam longint unsigned GAIN_INV_BASE = 64'd2608131496;  // 1/K, Q0.32
	localparam longint HALF_TURN_Q16 = 64'sd11796480;
	localparam longint FULL_TURN_Q16 = 64'sd23592960;
	localparam longint FULL_TURN_Q8  = 64'sd92160;

	// the tail wait after the last booked result leaves plenty of room
	localparam int TAIL_CYCLES  = r2p_pkg::CORDIC_STEPS + 24;
	localparam int RANDOM_ITEMS = 1500;
	// worst case: ~1525 items, each with its longest idle gap and stall run, well under this
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [15:0] mag;
		logic [16:0] ang;
	} polar_t;

	// directed row: point, whether the result is typed in, and that result
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic        known;
		polar_t      want;
	} probe_t;

	logic               clk;
	logic               arst_n;
	logic               pt_valid;
	logic               pt_stall;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic               res_valid;
	logic               res_stall;
	logic [15:0]        magnitude;
	logic [16:0]        angle_deg;

	polar_t polar_due [$];   // results owed by the block, oldest first
	polar_t got_due;
	probe_t probes [0:22];
	int     errors;
	int     results_seen;
	int     cycle_count;
	bit     sender_calm;

	rect_to_polar_degrees dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.magnitude (magnitude),
		.angle_deg (angle_deg)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// atan(2^-i) in degrees, 16 fraction bits, rounded
	function automatic longint atan_deg_q16(input int i);
		case (i)
			0:  return 2949120;
			1:  return 1740967;
			2:  return 919879;
			3:  return 466945;
			4:  return 234379;
			5:  return 117304;
			6:  return 58666;
			7:  return 29335;
			8:  return 14668;
			9:  return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			16: return 57;
			17: return 29;
			18: return 14;
			19: return 7;
			20: return 4;
			21: return 2;
			22: return 1;
			default: return 0;
		endcase
	endfunction

	// bit-exact polar form of one point
	function automatic polar_t predict_polar(input logic signed [15:0] px,
						 input logic signed [15:0] py);
		longint          xr;
		longint          yr;
		longint          zr;
		longint          base;
		longint          dxr;
		longint          dyr;
		longint          theta;
		longint          ang;
		longint unsigned kinv;
		longint unsigned mag;
		polar_t          res;
		zr   = 0;
		base = 0;
		if (px == 0 && py == 0) begin
			res.mag = '0;
			res.ang = '0;
			return res;
		end
		// left half plane: turn by 180 degrees so CORDIC sees -90..+90
		if (px < 0) begin
			xr   = -longint'(px) * 256;
			yr   = -longint'(py) * 256;
			base = HALF_TURN_Q16;
		end else begin
			xr = longint'(px) * 256;
			yr = longint'(py) * 256;
		end
		for (int i = 0; i < ROT_STEPS; i++) begin
			dxr = yr >>> i;   // arithmetic shift floors
			dyr = xr >>> i;
			if (yr >= 0) begin
				xr = xr + dxr;
				yr = yr - dyr;
				zr = zr + atan_deg_q16(i);
			end else begin
				xr = xr - dxr;
				yr = yr + dyr;
				zr = zr - atan_deg_q16(i);
			end
		end
		kinv = GAIN_INV_BASE + ((GAIN_INV_BASE * 2 / 3) >> (2 * ROT_STEPS));
		if (xr <= 0) begin
			mag = 0;
		end else begin
			mag = ($unsigned(xr) * kinv + (64'd1 << 39)) >> 40;
			if (mag > 65535)
				mag = 65535;
		end
		theta = base + zr;
		if (theta < 0)
			theta = theta + FULL_TURN_Q16;
		if (theta < 0)
			theta = 0;
		ang = (theta + 128) >>> 8;
		while (ang >= FULL_TURN_Q8)
			ang = ang - FULL_TURN_Q8;
		res.mag = mag[15:0];
		res.ang = ang[16:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch: result %0d %s: got %0d want %0d at %0t",
			 results_seen, what, got, want, $realtime);
		errors++;
	endtask

	// idle length between items: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Present one point, hold it until taken, then book its result.
	// Called and returns at a falling edge; valid stays high across
	// back-to-back items.
	task automatic send_point(input logic [15:0] px, input logic [15:0] py,
				  input bit known, input polar_t want);
		int gap;
		gap = sender_calm ? 0 : idle_len();
		if (gap > 0) begin
			pt_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pt_valid = 1'b1;
		x_coord  = px;
		y_coord  = py;
		do
			@(posedge clk);
		while (pt_stall);
		polar_due.push_back(known ? want : predict_polar(px, py));
		@(negedge clk);
	endtask

	// sender holds off until every booked result has come back
	task automatic drain_results();
		pt_valid = 1'b0;
		while (polar_due.size() != 0)
			@(negedge clk);
	endtask

	// pick one of a few awkward corner values
	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h8001;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	// Result side: random stall runs, some calm stretches with none at all
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(100, 300);
			else
				n = $urandom_range(0, 8);
			repeat (n) @(negedge clk) res_stall = 1'b0;
			n = idle_len() + 1;
			repeat (n) @(negedge clk) res_stall = 1'b1;
		end
	end

	// Checker: each taken result against the oldest booked one
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (polar_due.size() == 0) begin
				report_mismatch("arrived with none pending", magnitude, 0);
			end else begin
				got_due = polar_due.pop_front();
				if (magnitude !== got_due.mag)
					report_mismatch("magnitude", magnitude, got_due.mag);
				if (angle_deg !== got_due.ang)
					report_mismatch("angle_deg", angle_deg, got_due.ang);
			end
			results_seen++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rect_to_polar_degrees_tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [15:0] rx;
		logic [15:0] ry;
		polar_t      none;
		errors       = 0;
		results_seen = 0;
		cycle_count  = 0;
		sender_calm  = 1'b0;
		none         = '0;
		arst_n       = 1'b0;
		pt_valid     = 1'b0;
		x_coord      = '0;
		y_coord      = '0;

		// Directed rows. Only the origin is typed in; the rest go through
		// the predictor. Covered: axes at both extremes, the four corners,
		// unit steps around the origin, the 180 fold on both sides of the
		// negative x axis, and angles just under 360 that round to 0.
		probes = '{
			'{16'h0000, 16'h0000, 1'b1, '{16'd0, 17'd0}},   // origin
			'{16'h7FFF, 16'h0000, 1'b0, '0},
			'{16'h8000, 16'h0000, 1'b0, '0},
			'{16'h0000, 16'h7FFF, 1'b0, '0},
			'{16'h0000, 16'h8000, 1'b0, '0},
			'{16'h7FFF, 16'h7FFF, 1'b0, '0},
			'{16'h8000, 16'h8000, 1'b0, '0},
			'{16'h8000, 16'h7FFF, 1'b0, '0},
			'{16'h7FFF, 16'h8000, 1'b0, '0},
			'{16'h0001, 16'h0000, 1'b0, '0},
			'{16'hFFFF, 16'h0000, 1'b0, '0},
			'{16'h0000, 16'h0001, 1'b0, '0},
			'{16'h0000, 16'hFFFF, 1'b0, '0},
			'{16'h0001, 16'h0001, 1'b0, '0},
			'{16'hFFFF, 16'hFFFF, 1'b0, '0},
			'{16'hFFFF, 16'h0001, 1'b0, '0},
			'{16'h0001, 16'hFFFF, 1'b0, '0},
			'{16'h7FFF, 16'hFFFF, 1'b0, '0},   // just under 360
			'{16'h8000, 16'h0001, 1'b0, '0},   // just under 180
			'{16'h8000, 16'hFFFF, 1'b0, '0},   // just over 180
			'{16'h0100, 16'hFF00, 1'b0, '0},
			'{16'h5555, 16'hAAAA, 1'b0, '0},
			'{16'hAAAA, 16'h5555, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (probes[i])
			send_point(probes[i].x, probes[i].y, probes[i].known, probes[i].want);
		drain_results();

		// Random points: a mix of full-range, mid-range, small, axis, near-axis,
		// diagonal and corner-valued coordinates.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				sender_calm = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			rx = 16'($urandom);
			ry = 16'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: ;
				4: begin
					rx = 16'($urandom_range(0, 64)) - 16'd32;
					ry = 16'($urandom_range(0, 64)) - 16'd32;
				end
				5: begin
					if ($urandom_range(0, 1))
						rx = '0;
					else
						ry = '0;
				end
				6: begin
					ry = 16'($urandom_range(0, 4)) - 16'd2;
				end
				7: begin
					ry = $urandom_range(0, 1) ? rx : -rx;
				end
				8: begin
					rx = corner_value();
					ry = corner_value();
				end
				default: begin
					rx = 16'($urandom_range(0, 4095)) - 16'd2048;
					ry = 16'($urandom_range(0, 4095)) - 16'd2048;
				end
			endcase
			if ($urandom_range(0, 99) == 0) begin
				rx = '0;
				ry = '0;
			end
			send_point(rx, ry, 1'b0, none);
		end
		pt_valid = 1'b0;

		while (polar_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("rect_to_polar_degrees_tb OK");
		else
			$display("rect_to_polar_degrees_tb NOT OK");
		$finish;
	end

endmodule
